[rtl/core/sist_pkg.sv]
`timescale 1ns / 1ps

package sist_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 64;
  localparam int BEAM_W      = 16;
  localparam int ACTION_W    = 4;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic signed [KEY_W-1:0]  key;
    logic signed [BEAM_W-1:0] beam;
    logic [ACTION_W-1:0]      action;
  } rec_t;

  typedef struct packed {
    logic [1:0]        op;
    rec_t              rec;
    logic [ADDR_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             dropped;
    logic             bad;
    rec_t             rec;
  } res_t;

endpackage

[rtl/core/stable_insertion_sort_table_top.sv]
`timescale 1ns / 1ps

// Channel  Direction  Handshake          Word
// in       input      in_valid/in_stall  opcode, time_key, beam_number, action_code, read_index
// out      output     out_valid/out_stall entry_count, dropped_full, index_bad,
//                                         out_time, out_beam, out_action
// One word is taken at a time. An insert into a table of n records moves one stored
// record per cycle through the simple dual-port table RAM, up to the slot for the new key.
// A read passes through the READ state before its result is offered; other words do not.
// The result sits in an output register, so a new word is taken while it waits.
// Reset clears the count and all handshake state; no pass over the RAM is needed.

module stable_insertion_sort_table_top import sist_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               opcode,
  input  logic signed [KEY_W-1:0]  time_key,
  input  logic signed [BEAM_W-1:0] beam_number,
  input  logic [ACTION_W-1:0]      action_code,
  input  logic [ADDR_W-1:0]        read_index,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [CNT_W-1:0]         entry_count,
  output logic                     dropped_full,
  output logic                     index_bad,
  output logic signed [KEY_W-1:0]  out_time,
  output logic signed [BEAM_W-1:0] out_beam,
  output logic [ACTION_W-1:0]      out_action
);

  logic eng_idle;
  logic start;
  cmd_t cmd;
  logic res_valid;
  res_t res;
  logic res_take;
  res_t out_res;

  assign in_stall = !eng_idle;
  assign start    = in_valid && !in_stall;
  assign cmd      = '{op: opcode,
                      rec: '{key: time_key, beam: beam_number, action: action_code},
                      idx: read_index};
  assign res_take = res_valid && (!out_valid || !out_stall);

  sist_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cmd      (cmd),
    .idle     (eng_idle),
    .res_valid(res_valid),
    .res      (res),
    .res_take (res_take)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= res;
    end
  end

  assign entry_count  = out_res.cnt;
  assign dropped_full = out_res.dropped;
  assign index_bad    = out_res.bad;
  assign out_time     = out_res.rec.key;
  assign out_beam     = out_res.rec.beam;
  assign out_action   = out_res.rec.action;

endmodule

[rtl/core/sist_engine.sv]
`timescale 1ns / 1ps

module sist_engine import sist_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  cmd_t cmd,
  output logic idle,
  output logic res_valid,
  output res_t res,
  input  logic res_take
);

  state_t            state, state_next;
  rec_t              mem [TABLE_DEPTH];
  rec_t              rd_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  rec_t              wr_data;
  logic [CNT_W-1:0]  count, count_next;
  logic [ADDR_W-1:0] paddr, paddr_next;
  logic              pv, pv_next;
  logic              dropped, dropped_next;
  logic              bad, bad_next;
  rec_t              out_rec, out_rec_next;
  rec_t              hold, hold_next;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    paddr   <= paddr_next;
    pv      <= pv_next;
    dropped <= dropped_next;
    bad     <= bad_next;
    out_rec <= out_rec_next;
    hold    <= hold_next;
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    paddr_next   = paddr;
    pv_next      = pv;
    dropped_next = dropped;
    bad_next     = bad;
    out_rec_next = out_rec;
    hold_next    = hold;
    rd_en        = 1'b0;
    rd_addr      = paddr - 1'b1;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = hold;
    case (state)
      ST_IDLE: begin
        if (start) begin
          dropped_next = 1'b0;
          bad_next     = 1'b0;
          out_rec_next = '0;
          hold_next    = cmd.rec;
          state_next   = ST_EMIT;
          case (op_t'(cmd.op))
            OP_INSERT: begin
              if (count == CNT_W'(TABLE_DEPTH)) begin
                dropped_next = 1'b1;
              end else if (count == '0) begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = cmd.rec;
                count_next = count + 1'b1;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = ADDR_W'(count - 1'b1);
                paddr_next = ADDR_W'(count - 1'b1);
                pv_next    = 1'b1;
                state_next = ST_SCAN;
              end
            end
            OP_READ: begin
              if (CNT_W'(cmd.idx) >= count) begin
                bad_next = 1'b1;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = cmd.idx;
                state_next = ST_READ;
              end
            end
            OP_CLEAR: begin
              count_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (!pv) begin
          wr_en      = 1'b1;
          wr_addr    = '0;
          wr_data    = hold;
          count_next = count + 1'b1;
          state_next = ST_EMIT;
        end else if ($signed(rd_data.key) <= $signed(hold.key)) begin
          wr_en      = 1'b1;
          wr_addr    = paddr + 1'b1;
          wr_data    = hold;
          count_next = count + 1'b1;
          state_next = ST_EMIT;
        end else begin
          wr_en   = 1'b1;
          wr_addr = paddr + 1'b1;
          wr_data = rd_data;
          if (paddr == '0) begin
            pv_next = 1'b0;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = paddr - 1'b1;
            paddr_next = paddr - 1'b1;
          end
        end
      end
      ST_READ: begin
        out_rec_next = rd_data;
        state_next   = ST_EMIT;
      end
      ST_EMIT: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign idle      = (state == ST_IDLE);
  assign res_valid = (state == ST_EMIT);
  assign res       = '{cnt: count, dropped: dropped, bad: bad, rec: out_rec};

endmodule

[verif/stable_insertion_sort_table_top_test.sv]
`timescale 1ns / 1ps

module stable_insertion_sort_table_top_test;
  import sist_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [BEAM_W-1:0] BEAM_MAX = {1'b0, {(BEAM_W-1){1'b1}}};
  localparam logic signed [BEAM_W-1:0] BEAM_MIN = {1'b1, {(BEAM_W-1){1'b0}}};
  localparam int FILL_WORDS   = 200;
  localparam int RANDOM_WORDS = 320;
  localparam int QUIET_WORDS  = 60;
  localparam int STUCK_LIMIT  = 6000;
  localparam int DRAIN_CYCLES = 20;
  localparam int REPORT_CAP   = 40;

  class sorted_table_scoreboard;
    logic signed [KEY_W-1:0]  slot_key [TABLE_DEPTH];
    logic signed [BEAM_W-1:0] slot_beam [TABLE_DEPTH];
    logic [ACTION_W-1:0]      slot_action [TABLE_DEPTH];
    int entries = 0;
    int peak = 0;
    res_t awaited [$];
    int errors = 0;
    int checked = 0;
    int inserts = 0;
    int drops = 0;
    int reads = 0;
    int bad_reads = 0;
    int clears = 0;
    int ignored = 0;

    function void note_word(logic [1:0] op, logic signed [KEY_W-1:0] key,
                            logic signed [BEAM_W-1:0] beam, logic [ACTION_W-1:0] act,
                            logic [ADDR_W-1:0] idx);
      res_t want;
      int pos;
      int i;
      want = '0;
      case (op)
        OP_INSERT: begin
          inserts++;
          if (entries >= TABLE_DEPTH) begin
            want.dropped = 1'b1;
            drops++;
          end else begin
            pos = 0;
            while (pos < entries && slot_key[pos] <= key) pos++;
            for (i = entries; i > pos; i--) begin
              slot_key[i]    = slot_key[i-1];
              slot_beam[i]   = slot_beam[i-1];
              slot_action[i] = slot_action[i-1];
            end
            slot_key[pos]    = key;
            slot_beam[pos]   = beam;
            slot_action[pos] = act;
            entries++;
            if (entries > peak) peak = entries;
          end
        end
        OP_READ: begin
          reads++;
          if (idx >= entries) begin
            want.bad = 1'b1;
            bad_reads++;
          end else begin
            want.rec.key    = slot_key[idx];
            want.rec.beam   = slot_beam[idx];
            want.rec.action = slot_action[idx];
          end
        end
        OP_CLEAR: begin
          clears++;
          entries = 0;
        end
        default: ignored++;
      endcase
      want.cnt = CNT_W'(entries);
      awaited.push_back(want);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      checked++;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: result with nothing outstanding, expected none, actual %h",
                   $time, got);
        return;
      end
      want = awaited.pop_front();
      compare_field("entry_count", 64'(want.cnt), 64'(got.cnt));
      compare_field("dropped_full", 64'(want.dropped), 64'(got.dropped));
      compare_field("index_bad", 64'(want.bad), 64'(got.bad));
      compare_field("out_time", want.rec.key, got.rec.key);
      compare_field("out_beam", 64'(want.rec.beam), 64'(got.rec.beam));
      compare_field("out_action", 64'(want.rec.action), 64'(got.rec.action));
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               opcode = '0;
  logic signed [KEY_W-1:0]  time_key = '0;
  logic signed [BEAM_W-1:0] beam_number = '0;
  logic [ACTION_W-1:0]      action_code = '0;
  logic [ADDR_W-1:0]        read_index = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [CNT_W-1:0]         entry_count;
  logic                     dropped_full;
  logic                     index_bad;
  logic signed [KEY_W-1:0]  out_time;
  logic signed [BEAM_W-1:0] out_beam;
  logic [ACTION_W-1:0]      out_action;

  sorted_table_scoreboard board;
  bit quiet = 1'b0;
  bit gaps_on = 1'b1;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int stall_left = 0;
  int calm_left = 0;
  int stuck_cycles = 0;
  int holds_done = 0;

  stable_insertion_sort_table_top DUT (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    res_t got;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.cnt        = entry_count;
        got.dropped    = dropped_full;
        got.bad        = index_bad;
        got.rec.key    = out_time;
        got.rec.beam   = out_beam;
        got.rec.action = out_action;
        board.check_result(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        holds_done++;
        hold_left = $urandom_range(150, 250) - 1;
        out_stall <= 1'b1;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_stall <= 1'b1;
      end else begin
        if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(20, 80);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("%0t: timeout, no word moved for %0d cycles, %0d results outstanding",
               $time, STUCK_LIMIT, board.awaited.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic send_word(input logic [1:0] op, input logic signed [KEY_W-1:0] key,
                           input logic signed [BEAM_W-1:0] beam,
                           input logic [ACTION_W-1:0] act, input logic [ADDR_W-1:0] idx);
    int gap;
    if (!quiet && gaps_on && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    time_key    <= key;
    beam_number <= beam;
    action_code <= act;
    read_index  <= idx;
    do @(posedge clk); while (in_stall);
    board.note_word(op, key, beam, act, idx);
  endtask

  task automatic put_record(input logic signed [KEY_W-1:0] key,
                            input logic signed [BEAM_W-1:0] beam,
                            input logic [ACTION_W-1:0] act);
    send_word(OP_INSERT, key, beam, act, ADDR_W'($urandom_range(0, TABLE_DEPTH - 1)));
  endtask

  task automatic fetch_entry(input logic [ADDR_W-1:0] idx);
    send_word(OP_READ, {$urandom, $urandom}, BEAM_W'($urandom), ACTION_W'($urandom), idx);
  endtask

  task automatic wipe_table();
    send_word(OP_CLEAR, {$urandom, $urandom}, BEAM_W'($urandom), ACTION_W'($urandom),
              ADDR_W'($urandom_range(0, TABLE_DEPTH - 1)));
  endtask

  task automatic send_unused();
    send_word(OP_UNUSED, {$urandom, $urandom}, BEAM_W'($urandom), ACTION_W'($urandom),
              ADDR_W'($urandom_range(0, TABLE_DEPTH - 1)));
  endtask

  function automatic logic signed [KEY_W-1:0] pick_key();
    logic signed [KEY_W-1:0] key;
    int sel;
    sel = $urandom_range(0, 5);
    case (sel)
      0, 1: key = {$urandom, $urandom};
      2: key = KEY_W'($urandom_range(0, 7));
      3: key = -KEY_W'($urandom_range(1, 8));
      4: begin
        case ($urandom_range(0, 3))
          0: key = KEY_MIN;
          1: key = KEY_MAX;
          2: key = '0;
          default: key = '1;
        endcase
      end
      default: key = KEY_W'($signed($urandom));
    endcase
    return key;
  endfunction

  initial begin
    int i;
    int words;
    int session;
    int len;
    int pick;
    board = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed words: empty reads, key and field extremes, equal keys, odd opcode.
    fetch_entry('0);
    fetch_entry(ADDR_W'(TABLE_DEPTH - 1));
    put_record('0, 16'sd1, 4'd3);
    put_record(KEY_MAX, BEAM_MAX, 4'd15);
    put_record(KEY_MIN, BEAM_MIN, 4'd0);
    put_record('0, 16'sd2, 4'd9);
    put_record('1, -16'sd1, 4'd5);
    put_record('0, 16'sd3, 4'd10);
    for (i = 0; i <= 6; i++) fetch_entry(ADDR_W'(i));
    send_unused();
    wipe_table();
    fetch_entry('0);
    send_unused();

    // Build a long table, insert KEY_MIN so all larger keys shift, then read across it.
    repeat (FILL_WORDS) put_record(pick_key(), BEAM_W'($urandom), ACTION_W'($urandom));
    put_record(pick_key(), BEAM_W'($urandom), ACTION_W'($urandom));
    put_record(KEY_MIN, BEAM_MIN, 4'd0);
    fetch_entry('0);
    fetch_entry(ADDR_W'(FILL_WORDS + 1));
    fetch_entry(ADDR_W'(TABLE_DEPTH - 1));
    repeat (12) fetch_entry(ADDR_W'($urandom_range(0, FILL_WORDS + 1)));
    send_unused();
    wipe_table();

    words = 0;
    session = 0;
    while (words < RANDOM_WORDS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      if (words >= RANDOM_WORDS - QUIET_WORDS) quiet = 1'b1;
      if (session == 4 || session == 11) hold_req = 1'b1;
      if (board.entries > 40 || $urandom_range(0, 3) == 0) begin
        wipe_table();
        words++;
      end
      len = $urandom_range(4, 30);
      repeat (len) begin
        pick = $urandom_range(0, 19);
        if (pick < 9) begin
          put_record(pick_key(), BEAM_W'($urandom), ACTION_W'($urandom));
          words++;
        end else if (pick < 17) begin
          if (board.entries != 0 && $urandom_range(0, 4) != 0)
            fetch_entry(ADDR_W'($urandom_range(0, board.entries - 1)));
          else
            fetch_entry(ADDR_W'($urandom_range(0, TABLE_DEPTH - 1)));
          words++;
        end else if (pick < 18) begin
          wipe_table();
          words++;
        end else if (pick < 19) begin
          send_unused();
        end else begin
          if (board.entries != 0)
            put_record(board.slot_key[$urandom_range(0, board.entries - 1)],
                       BEAM_W'($urandom), ACTION_W'($urandom));
          else
            put_record(pick_key(), BEAM_W'($urandom), ACTION_W'($urandom));
          words++;
        end
      end
      session++;
    end

    in_valid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d inserts (%0d dropped on a full table), %0d reads (%0d out of range),",
             board.inserts, board.drops, board.reads, board.bad_reads);
    $display("%0d clears, %0d unused opcodes, %0d results checked, peak fill %0d, %0d long holds.",
             board.clears, board.ignored, board.checked, board.peak, holds_done);
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
